// File: hw/rtl/rse_pkg.sv
// ============================================================================
// rse_pkg: shared definitions for the RPN stack evaluator
// Operation and status codes, field widths and the controller state type.
// ============================================================================
package rse_pkg;

  // Default stack size and fixed field widths
  localparam int STACK_DEPTH_DEF = 8;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 3;
  localparam int ST_W            = 3;
  localparam int OUT_DEPTH_W     = 4;

  // Operation codes; the two codes above clear are illegal
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [ST_W-1:0] ST_ILLEGAL   = 3'd4;
  localparam logic [ST_W-1:0] ST_HALTED    = 3'd5;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item
    S_RDB,    // right operand arrives from the stack memory
    S_RDA,    // left operand arrives from the stack memory
    S_EXEC,   // add, subtract, multiply, or divider launch
    S_DIV,    // serial divide in progress
    S_WB,     // write the result back onto the stack
    S_FIN     // hand the result to the output register
  } state_t;

endpackage

// File: hw/rtl/rse_stack_mem.sv
// ============================================================================
// rse_stack_mem: stack storage
// Single write port, single read port with registered read data.
// ============================================================================
module rse_stack_mem #(
  parameter int DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int WIDTH = rse_pkg::DATA_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/rse_divider.sv
// ============================================================================
// rse_divider: serial signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating
// toward zero. Quotient wraps for the most negative value over minus one.
// ============================================================================
module rse_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rse_pkg::DATA_W-1:0]  dividend,
  input  logic [rse_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [rse_pkg::DATA_W-1:0]  quotient
);

  localparam int W  = rse_pkg::DATA_W;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  mag_b;
  logic          neg;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic [W-1:0]  rem_step;
  logic [W-1:0]  quo_step;

  // One restoring step
  always_comb begin
    rem_sh = {rem, quo[W-1]};
    diff   = rem_sh - {1'b0, mag_b};
    if (!diff[W]) begin
      rem_step = diff[W-1:0];
      quo_step = {quo[W-2:0], 1'b1};
    end else begin
      rem_step = rem_sh[W-1:0];
      quo_step = {quo[W-2:0], 1'b0};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      mag_b <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg   <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      rem <= rem_step;
      quo <= quo_step;
      if (cnt == LAST) begin
        quotient <= neg ? (W'(0) - quo_step) : quo_step;
      end
    end
  end

endmodule

// File: hw/rtl/rpn_stack_evaluator_unit.sv
// ============================================================================
// rpn_stack_evaluator_unit: Reverse Polish evaluator on a bounded stack
// One token per item: push, add, subtract, multiply, divide or clear.
// Each item yields status, bottom stack entry and depth.
// ============================================================================
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_stall  | operation, operand_value
//  output   | out_valid / out_stall| status, bottom_value, depth
//
// One item is in work at a time. Push, clear, illegal and halted items go
// straight to output; add/subtract/multiply take two stack reads, execute
// and write-back; divide adds the serial divider at one quotient bit per
// cycle; a divide by zero skips divider and write-back. Reset clears depth,
// halt and the bottom entry at once; no clearing pass. The output register
// frees the input side: the next item is taken while a result waits under
// out_stall.
module rpn_stack_evaluator_unit #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rse_pkg::OP_W-1:0]           operation,
  input  logic signed [rse_pkg::DATA_W-1:0]  operand_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rse_pkg::ST_W-1:0]           status,
  output logic signed [rse_pkg::DATA_W-1:0]  bottom_value,
  output logic [rse_pkg::OUT_DEPTH_W-1:0]    depth
);

  localparam int W  = rse_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] D_ONE      = DW'(1);
  localparam logic [DW-1:0] D_TWO      = DW'(2);

  rse_pkg::state_t state;
  rse_pkg::state_t state_next;

  // Architectural state
  logic [DW-1:0]           stk_depth;
  logic                    halted;
  logic [W-1:0]            bottom;

  // Per-item work registers
  logic [rse_pkg::OP_W-1:0] op_q;
  logic [W-1:0]             opa;
  logic [W-1:0]             opb;
  logic [W-1:0]             result;
  logic [rse_pkg::ST_W-1:0] res_status;

  // Memory and divider connections
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic [AW-1:0] rd_addr;
  logic [W-1:0]  rd_data;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quot;

  // Handshake and derived depth values
  logic          accept;
  logic          slot_free;
  logic          in_binary;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_m2;
  logic [DW-1:0] wb_index;
  logic          has_two;
  logic          div_by_zero;

  assign accept      = in_valid && !in_stall;
  assign slot_free   = !out_valid || !out_stall;
  assign in_binary   = (operation == rse_pkg::OP_ADD) || (operation == rse_pkg::OP_SUB) ||
                       (operation == rse_pkg::OP_MUL) || (operation == rse_pkg::OP_DIV);
  assign depth_m1    = stk_depth - D_ONE;
  assign depth_m2    = stk_depth - D_TWO;
  assign has_two     = (stk_depth >= D_TWO);
  assign wb_index    = has_two ? depth_m2 : '0;
  assign div_by_zero = (op_q == rse_pkg::OP_DIV) && (opb == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rse_pkg::S_IDLE: begin
        if (accept) begin
          if (in_binary && !halted) begin
            state_next = rse_pkg::S_RDB;
          end else begin
            state_next = rse_pkg::S_FIN;
          end
        end
      end
      rse_pkg::S_RDB:  state_next = rse_pkg::S_RDA;
      rse_pkg::S_RDA:  state_next = rse_pkg::S_EXEC;
      rse_pkg::S_EXEC: begin
        if (op_q == rse_pkg::OP_DIV) begin
          state_next = div_by_zero ? rse_pkg::S_FIN : rse_pkg::S_DIV;
        end else begin
          state_next = rse_pkg::S_WB;
        end
      end
      rse_pkg::S_DIV: begin
        if (div_done) begin
          state_next = rse_pkg::S_WB;
        end
      end
      rse_pkg::S_WB:   state_next = rse_pkg::S_FIN;
      rse_pkg::S_FIN: begin
        if (slot_free) begin
          state_next = rse_pkg::S_IDLE;
        end
      end
      default: state_next = rse_pkg::S_IDLE;
    endcase
  end

  // Controller outputs: stall, memory ports, divider launch
  always_comb begin
    in_stall  = 1'b1;
    rd_addr   = depth_m1[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = stk_depth[AW-1:0];
    wr_data   = operand_value;
    div_start = 1'b0;
    unique case (state)
      rse_pkg::S_IDLE: begin
        in_stall = 1'b0;
        wr_en    = accept && !halted && (operation == rse_pkg::OP_PUSH) &&
                   (stk_depth != DEPTH_FULL);
      end
      rse_pkg::S_RDB: rd_addr = depth_m2[AW-1:0];
      rse_pkg::S_EXEC: div_start = (op_q == rse_pkg::OP_DIV) && !div_by_zero;
      rse_pkg::S_WB: begin
        wr_en   = 1'b1;
        wr_addr = wb_index[AW-1:0];
        wr_data = result;
      end
      default: ;
    endcase
  end

  // State, stack bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rse_pkg::S_IDLE;
      stk_depth  <= '0;
      halted     <= 1'b0;
      bottom     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // Output valid: rises when a result is loaded, drops when taken
      if ((state == rse_pkg::S_FIN) && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        // Decode the item; short operations finish here
        rse_pkg::S_IDLE: begin
          if (accept) begin
            op_q <= operation;
            if (operation == rse_pkg::OP_CLEAR) begin
              stk_depth  <= '0;
              halted     <= 1'b0;
              bottom     <= '0;
              res_status <= rse_pkg::ST_OK;
            end else if (halted) begin
              res_status <= rse_pkg::ST_HALTED;
            end else begin
              unique case (operation) inside
                rse_pkg::OP_PUSH: begin
                  if (stk_depth == DEPTH_FULL) begin
                    res_status <= rse_pkg::ST_OVERFLOW;
                  end else begin
                    stk_depth  <= stk_depth + D_ONE;
                    res_status <= rse_pkg::ST_OK;
                    if (stk_depth == '0) begin
                      bottom <= operand_value;
                    end
                  end
                end
                rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL, rse_pkg::OP_DIV: ;
                default: begin
                  halted     <= 1'b1;
                  res_status <= rse_pkg::ST_ILLEGAL;
                end
              endcase
            end
          end
        end
        // Operands; a missing one reads as zero
        rse_pkg::S_RDB: opb <= (stk_depth != '0) ? rd_data : '0;
        rse_pkg::S_RDA: opa <= has_two ? rd_data : '0;
        rse_pkg::S_EXEC: begin
          if (op_q == rse_pkg::OP_DIV) begin
            if (div_by_zero) begin
              halted     <= 1'b1;
              stk_depth  <= wb_index;
              res_status <= rse_pkg::ST_DIVZERO;
            end
          end else if (op_q == rse_pkg::OP_ADD) begin
            result <= opa + opb;
          end else if (op_q == rse_pkg::OP_SUB) begin
            result <= opa - opb;
          end else begin
            result <= W'(opa * opb);
          end
        end
        rse_pkg::S_DIV: begin
          if (div_done) begin
            result <= div_quot;
          end
        end
        // Push the result where the left operand was
        rse_pkg::S_WB: begin
          stk_depth  <= wb_index + D_ONE;
          res_status <= has_two ? rse_pkg::ST_OK : rse_pkg::ST_UNDERFLOW;
          if (wb_index == '0) begin
            bottom <= result;
          end
        end
        rse_pkg::S_FIN: begin
          if (slot_free) begin
            status       <= res_status;
            bottom_value <= bottom;
            depth        <= rse_pkg::OUT_DEPTH_W'(stk_depth);
          end
        end
        default: ;
      endcase
    end
  end

  rse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

// File: hw/rtl/rse_checker.sv
// ============================================================================
// rse_checker: port-level checks for the RPN stack evaluator
// Watches the top-level ports only; attached by bind.
// ============================================================================
module rse_checker #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [rse_pkg::OP_W-1:0]           operation,
  input logic signed [rse_pkg::DATA_W-1:0]  operand_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [rse_pkg::ST_W-1:0]           status,
  input logic signed [rse_pkg::DATA_W-1:0]  bottom_value,
  input logic [rse_pkg::OUT_DEPTH_W-1:0]    depth
);

  localparam logic [rse_pkg::OUT_DEPTH_W-1:0] FULL_DEPTH =
    rse_pkg::OUT_DEPTH_W'(STACK_DEPTH);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
    $stable(bottom_value) && $stable(depth))
    else $error("stalled result changed");

  // One item in work: stall rises right after an accepted item
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // A dropped push leaves a full stack
  a_overflow_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rse_pkg::ST_OVERFLOW) |-> depth == FULL_DEPTH)
    else $error("overflow without full stack");

  // Underflow always leaves just the pushed result
  a_underflow_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rse_pkg::ST_UNDERFLOW) |-> depth == 4'd1)
    else $error("underflow with wrong depth");

endmodule

bind rpn_stack_evaluator_unit rse_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rse_checker (.*);

// File: tb/rpn_stack_evaluator_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// rpn_stack_evaluator_unit_tb: self-checking bench for the RPN stack evaluator
// Drives token items through the valid/stall input channel and keeps a shadow
// copy of the stack. Every item predicts one status/bottom/depth result, and
// each result taken from the output channel is checked against the oldest one.
// A directed opener hits the corner cases, then mostly well-formed random
// expressions run with bursty input and a random output stall pattern.
// ============================================================================

// One predicted result item
typedef struct packed {
  logic [rse_pkg::ST_W-1:0]        status;
  logic [rse_pkg::DATA_W-1:0]      bottom;
  logic [rse_pkg::OUT_DEPTH_W-1:0] depth;
} rpn_outcome_t;

// Shadow stack: predicts the result of each accepted token, checks outputs
class rpn_stack_shadow;
  logic [rse_pkg::DATA_W-1:0] entries [rse_pkg::STACK_DEPTH_DEF];
  int unsigned                fill;
  bit                         halted;
  rpn_outcome_t               awaited [$];
  int unsigned                mismatch_count;

  function new();
    foreach (entries[i]) entries[i] = '0;
    fill           = 0;
    halted         = 1'b0;
    mismatch_count = 0;
  endfunction

  // Pop the top entry; an empty stack gives zero and flags a short stack
  function logic [rse_pkg::DATA_W-1:0] take_top(inout bit short);
    if (fill == 0) begin
      short = 1'b1;
      return '0;
    end
    fill--;
    return entries[fill];
  endfunction

  // Signed division truncating toward zero, done on magnitudes so that the
  // most negative value over minus one wraps instead of trapping
  function logic [rse_pkg::DATA_W-1:0] quotient(logic [rse_pkg::DATA_W-1:0] num,
                                                logic [rse_pkg::DATA_W-1:0] den);
    logic [rse_pkg::DATA_W-1:0] num_mag;
    logic [rse_pkg::DATA_W-1:0] den_mag;
    logic [rse_pkg::DATA_W-1:0] q;
    num_mag = num[rse_pkg::DATA_W-1] ? -num : num;
    den_mag = den[rse_pkg::DATA_W-1] ? -den : den;
    q       = num_mag / den_mag;
    return (num[rse_pkg::DATA_W-1] ^ den[rse_pkg::DATA_W-1]) ? -q : q;
  endfunction

  // Apply one accepted token to the shadow state and queue its result
  function void note_token(logic [rse_pkg::OP_W-1:0] op, logic [rse_pkg::DATA_W-1:0] val);
    rpn_outcome_t               res;
    logic [rse_pkg::DATA_W-1:0] lhs;
    logic [rse_pkg::DATA_W-1:0] rhs;
    logic [rse_pkg::DATA_W-1:0] outcome;
    bit                         short;
    res.status = rse_pkg::ST_OK;
    short      = 1'b0;
    if (op == rse_pkg::OP_CLEAR) begin
      foreach (entries[i]) entries[i] = '0;
      fill   = 0;
      halted = 1'b0;
    end else if (halted) begin
      res.status = rse_pkg::ST_HALTED;
    end else if (op == rse_pkg::OP_PUSH) begin
      if (fill < rse_pkg::STACK_DEPTH_DEF) begin
        entries[fill] = val;
        fill++;
      end else begin
        res.status = rse_pkg::ST_OVERFLOW;
      end
    end else if (op >= rse_pkg::OP_ADD && op <= rse_pkg::OP_DIV) begin
      rhs = take_top(short);
      lhs = take_top(short);
      if (op == rse_pkg::OP_DIV && rhs == '0) begin
        // operands consumed, nothing pushed; wins over underflow
        halted     = 1'b1;
        res.status = rse_pkg::ST_DIVZERO;
      end else begin
        case (op)
          rse_pkg::OP_ADD: outcome = lhs + rhs;
          rse_pkg::OP_SUB: outcome = lhs - rhs;
          rse_pkg::OP_MUL: outcome = lhs * rhs;
          default:         outcome = quotient(lhs, rhs);
        endcase
        // two pops just happened, so there is always room
        entries[fill] = outcome;
        fill++;
        if (short) res.status = rse_pkg::ST_UNDERFLOW;
      end
    end else begin
      halted     = 1'b1;
      res.status = rse_pkg::ST_ILLEGAL;
    end
    res.bottom = entries[0];
    res.depth  = rse_pkg::OUT_DEPTH_W'(fill);
    awaited.push_back(res);
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Compare one output item with the oldest prediction
  task check_result(logic [rse_pkg::ST_W-1:0] st, logic [rse_pkg::DATA_W-1:0] bot,
                    logic [rse_pkg::OUT_DEPTH_W-1:0] dep);
    rpn_outcome_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("unexpected item: status %0d bottom %h depth %0d",
                                st, bot, dep));
      return;
    end
    want = awaited.pop_front();
    if (st !== want.status)
      report_mismatch($sformatf("status %0d, predicted %0d", st, want.status));
    if (bot !== want.bottom)
      report_mismatch($sformatf("bottom_value %h, predicted %h", bot, want.bottom));
    if (dep !== want.depth)
      report_mismatch($sformatf("depth %0d, predicted %0d", dep, want.depth));
  endtask
endclass

module rpn_stack_evaluator_unit_tb;

  localparam int RANDOM_TOKENS = 1325;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int OPW           = rse_pkg::OP_W;
  localparam int DW            = rse_pkg::DATA_W;

  // The two codes above clear are illegal
  localparam logic [OPW-1:0] OP_BAD_SIX   = 3'd6;
  localparam logic [OPW-1:0] OP_BAD_SEVEN = 3'd7;

  logic                                 clk           = 1'b0;
  logic                                 rst           = 1'b1;
  logic                                 in_valid      = 1'b0;
  logic                                 in_stall;
  logic [OPW-1:0]                       operation     = rse_pkg::OP_CLEAR;
  logic signed [DW-1:0]                 operand_value = '0;
  logic                                 out_valid;
  logic                                 out_stall     = 1'b0;
  logic [rse_pkg::ST_W-1:0]             status;
  logic signed [DW-1:0]                 bottom_value;
  logic [rse_pkg::OUT_DEPTH_W-1:0]      depth;

  rpn_stack_shadow shadow = new();
  int unsigned     cycle_count = 0;

  rpn_stack_evaluator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .bottom_value  (bottom_value),
    .depth         (depth)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Present one token and hold it until the block takes it
  task automatic send_token(logic [OPW-1:0] op, logic [DW-1:0] val);
    operation     <= op;
    operand_value <= val;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_token(op, val);
  endtask

  // Operand mix: full random, small signed, extremes and zero
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4, 5:       return DW'($urandom_range(0, 40)) - DW'(20);
      6:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:    return '0;
    endcase
  endfunction

  // Mostly well-formed expressions; some noise, illegal codes and clears
  function automatic void pick_token(output logic [OPW-1:0] op,
                                     output logic [DW-1:0] val);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    val  = pick_operand();
    if (shadow.halted)
      op = (roll < 85) ? rse_pkg::OP_CLEAR : OPW'($urandom_range(0, 7));
    else if (roll < 3)
      op = roll[0] ? OP_BAD_SIX : OP_BAD_SEVEN;
    else if (roll < 6)
      op = rse_pkg::OP_CLEAR;
    else if (roll < 12)
      op = OPW'($urandom_range(0, 7));
    else if (shadow.fill < 2 || (shadow.fill < rse_pkg::STACK_DEPTH_DEF && roll < 58) ||
             roll >= 96)
      op = rse_pkg::OP_PUSH;
    else
      op = OPW'($urandom_range(rse_pkg::OP_ADD, rse_pkg::OP_DIV));
  endfunction

  // Output side: stall pattern switches at random among four modes
  initial begin
    int unsigned span;
    int unsigned mode;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_result(status, bottom_value, depth);
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [OPW-1:0] op;
    logic [DW-1:0]  val;
    int unsigned    counted;
    int unsigned    burst;
    int unsigned    gap;
    bit             ignored;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: underflow on an empty stack
    send_token(rse_pkg::OP_ADD, 32'd0);
    // most negative over minus one wraps
    send_token(rse_pkg::OP_PUSH, 32'h8000_0000);
    send_token(rse_pkg::OP_PUSH, 32'hffff_ffff);
    send_token(rse_pkg::OP_DIV, 32'd0);
    // division truncates toward zero: 7 / -2 = -3
    send_token(rse_pkg::OP_PUSH, 32'd7);
    send_token(rse_pkg::OP_PUSH, 32'hffff_fffe);
    send_token(rse_pkg::OP_DIV, 32'h1234_5678);
    send_token(rse_pkg::OP_MUL, 32'd0);
    send_token(rse_pkg::OP_SUB, 32'd0);
    // illegal code halts; later items are ignored until clear
    send_token(OP_BAD_SIX, 32'd0);
    send_token(rse_pkg::OP_PUSH, 32'h7fff_ffff);
    send_token(rse_pkg::OP_CLEAR, 32'hffff_ffff);
    // divide by zero on an empty stack: divide-by-zero beats underflow
    send_token(rse_pkg::OP_DIV, 32'd0);
    send_token(OP_BAD_SEVEN, 32'd0);
    send_token(rse_pkg::OP_CLEAR, 32'd0);
    // fill the stack, then overflow
    for (int k = 0; k <= rse_pkg::STACK_DEPTH_DEF; k++)
      send_token(rse_pkg::OP_PUSH, k[0] ? 32'h7fff_ffff : 32'h8000_0000);

    // Random: bursts of tokens with random gaps between them
    counted = 0;
    while (counted < RANDOM_TOKENS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick_token(op, val);
        ignored = shadow.halted && op != rse_pkg::OP_CLEAR;
        send_token(op, val);
        if (!ignored) counted++;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(9, 50);
        default:       gap = $urandom_range(1, 8);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch a while for stray items
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatch_count == 0 && shadow.awaited.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: rpn_stack_evaluator_unit.f
hw/rtl/rse_pkg.sv
hw/rtl/rse_stack_mem.sv
hw/rtl/rse_divider.sv
hw/rtl/rpn_stack_evaluator_unit.sv
hw/rtl/rse_checker.sv
tb/rpn_stack_evaluator_unit_tb.sv
